>>> sv/scalar_kalman_filter_macros.svh
// assertion macros shared by the filter modules
// each macro samples on clk and is disabled while rst_n is low
`ifndef SCALAR_KALMAN_FILTER_MACROS_SVH
`define SCALAR_KALMAN_FILTER_MACROS_SVH

// same-cycle implication
`define SKF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SKF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/skf_pkg.sv
package skf_pkg;

  // q16.16 limits
  localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] Q_ONE = 32'sd65536;

  // reset values of the configuration registers
  localparam logic signed [31:0] STATE_GAIN_RST   = 32'sd65536;
  localparam logic signed [31:0] MEASURE_GAIN_RST = 32'sd65536;
  localparam logic [30:0]        PROC_NOISE_RST   = 31'd655;
  localparam logic [30:0]        MEAS_NOISE_RST   = 31'd65536;

  // gain divider: 32 bit magnitude shifted up by 16
  localparam int DIV_STEPS = 48;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_STATE_GAIN    = 2'd0,
    REG_MEASURE_GAIN  = 2'd1,
    REG_PROCESS_NOISE = 2'd2,
    REG_MEASURE_NOISE = 2'd3
  } skf_reg_t;

  // operand pair for the shared multiplier
  typedef enum logic [3:0] {
    MUL_NONE,
    MUL_A_E,
    MUL_A_P,
    MUL_T_A,
    MUL_H_PP,
    MUL_HP_H,
    MUL_H_EP,
    MUL_G_IN,
    MUL_G_H,
    MUL_OM_PP
  } skf_mul_t;

  // destination of the rounded product
  typedef enum logic [3:0] {
    WR_NONE,
    WR_EPRED,
    WR_T,
    WR_INNOV,
    WR_PPRED,
    WR_HP,
    WR_DEN,
    WR_EST,
    WR_OM,
    WR_COV
  } skf_wr_t;

  // controller to datapath
  typedef struct packed {
    skf_mul_t mul_sel;
    skf_wr_t  wr_sel;
    logic     in_load;
    logic     div_start;
    logic     gain_zero;
    logic     out_load;
  } skf_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic den_pos;
    logic div_done;
  } skf_sts_t;

  // saturate a 33 bit sum to 32 bits
  function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
    logic signed [31:0] r;
    if (v[32] != v[31]) begin
      r = v[32] ? Q_MIN : Q_MAX;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // round half up a q32.32 product to q16.16 and saturate
  function automatic logic signed [31:0] qround(input logic signed [63:0] p);
    logic signed [63:0] s;
    logic signed [47:0] sh;
    logic signed [31:0] r;
    s  = p + 64'sd32768;
    sh = s[63:16];
    if ((sh[47:31] != {17{1'b0}}) && (sh[47:31] != {17{1'b1}})) begin
      r = sh[47] ? Q_MIN : Q_MAX;
    end else begin
      r = sh[31:0];
    end
    return r;
  endfunction

endpackage

>>> sv/scalar_kalman_filter.sv
// a word runs through the fixed multiply steps, plus the bit-serial gain divider when
//   the gain denominator is positive (otherwise the gain is zero and the result degenerate)
// one word at a time (in_ready only while idle); the shared multiplier and divider work in turn
// a result word waits in an output register, so the next input word is taken meanwhile
// reset (rst_n low, synchronous): registers back to A=1.0, H=1.0, Q=655, R=1.0,
//   estimate and covariance cleared, both channels idle
module scalar_kalman_filter (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_measurement,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_filtered_value,
  output logic               out_degenerate,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_wdata
);

  skf_pkg::skf_cmd_t cmd;
  skf_pkg::skf_sts_t sts;

  // sequencer
  skf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // arithmetic and state
  skf_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_measurement     (in_measurement),
    .out_filtered_value (out_filtered_value),
    .out_degenerate     (out_degenerate)
  );

endmodule

>>> sv/skf_div.sv
`include "scalar_kalman_filter_macros.svh"

module skf_div (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic signed [31:0]  num,
  input  logic [30:0]         den,
  output logic                done,
  output logic signed [31:0]  quo
);

  logic                          busy_r;
  logic                          done_r;
  logic [skf_pkg::DIV_CNT_W-1:0] cnt_r;
  logic [30:0]                   rem_r;
  logic [30:0]                   den_r;
  logic [47:0]                   dq_r;
  logic                          neg_r;
  logic signed [31:0]            quo_r;

  logic [31:0]        mag;
  logic [31:0]        trial;
  logic               ge;
  logic [30:0]        rem_nxt;
  logic [47:0]        dq_nxt;
  logic               pos_ovf;
  logic               neg_ovf;
  logic signed [31:0] quo_nxt;

  // magnitude of the numerator
  assign mag = num[31] ? (~num + 32'd1) : num;

  // one restoring step per cycle
  always_comb begin
    trial   = {rem_r, dq_r[47]};
    ge      = trial >= {1'b0, den_r};
    rem_nxt = ge ? 31'(trial - {1'b0, den_r}) : trial[30:0];
    dq_nxt  = {dq_r[46:0], ge};
  end

  // sign and saturation of the final quotient
  always_comb begin
    pos_ovf = |dq_nxt[47:31];
    neg_ovf = (|dq_nxt[47:32]) || (dq_nxt[31] && (|dq_nxt[30:0]));
    if (neg_r) begin
      quo_nxt = neg_ovf ? skf_pkg::Q_MIN : (~dq_nxt[31:0] + 32'd1);
    end else begin
      quo_nxt = pos_ovf ? skf_pkg::Q_MAX : dq_nxt[31:0];
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= skf_pkg::DIV_CNT_W'(skf_pkg::DIV_STEPS - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // shift registers
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      dq_r  <= {mag, 16'd0};
      neg_r <= num[31];
      den_r <= den;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      dq_r  <= dq_nxt;
      if (cnt_r == '0) begin
        quo_r <= quo_nxt;
      end
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

  `SKF_ASSERT_NOW(a_div_start_idle, start, !busy_r, "divider started while busy")
  `SKF_ASSERT_NEXT(a_div_done_idle, done_r, !done_r, "divider done held for two cycles")
  `SKF_ASSERT_NEXT(a_div_finish, busy_r && (cnt_r == '0), done_r && !busy_r, "divider did not finish")

endmodule

>>> sv/skf_dp.sv
module skf_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  skf_pkg::skf_cmd_t  cmd,
  output skf_pkg::skf_sts_t  sts,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_wdata,
  input  logic signed [31:0] in_measurement,
  output logic signed [31:0] out_filtered_value,
  output logic               out_degenerate
);

  // configuration
  logic signed [31:0] sg_r;
  logic signed [31:0] mg_r;
  logic [30:0]        qn_r;
  logic [30:0]        rn_r;

  // filter state
  logic signed [31:0] est_r;
  logic signed [31:0] cov_r;

  // step temporaries
  logic signed [31:0] z_r;
  logic signed [31:0] ep_r;
  logic signed [31:0] t_r;
  logic signed [31:0] in_r;
  logic signed [31:0] pp_r;
  logic signed [31:0] hp_r;
  logic signed [31:0] den_r;
  logic signed [31:0] om_r;
  logic signed [31:0] gain_r;
  logic               degen_r;
  logic signed [63:0] prod_r;
  logic signed [31:0] out_fv_r;
  logic               out_dg_r;

  logic signed [31:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [63:0] mul_p;
  logic signed [31:0] qm;
  logic               div_done;
  logic signed [31:0] div_quo;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sg_r <= skf_pkg::STATE_GAIN_RST;
      mg_r <= skf_pkg::MEASURE_GAIN_RST;
      qn_r <= skf_pkg::PROC_NOISE_RST;
      rn_r <= skf_pkg::MEAS_NOISE_RST;
    end else if (cfg_we) begin
      unique case (skf_pkg::skf_reg_t'(cfg_index))
        skf_pkg::REG_STATE_GAIN:    sg_r <= cfg_wdata;
        skf_pkg::REG_MEASURE_GAIN:  mg_r <= cfg_wdata;
        skf_pkg::REG_PROCESS_NOISE: qn_r <= cfg_wdata[30:0];
        skf_pkg::REG_MEASURE_NOISE: rn_r <= cfg_wdata[30:0];
        default: ;
      endcase
    end
  end

  // operand select for the shared multiplier
  always_comb begin
    case (cmd.mul_sel)
      skf_pkg::MUL_A_E:   begin mul_a = sg_r;   mul_b = est_r; end
      skf_pkg::MUL_A_P:   begin mul_a = sg_r;   mul_b = cov_r; end
      skf_pkg::MUL_T_A:   begin mul_a = t_r;    mul_b = sg_r;  end
      skf_pkg::MUL_H_PP:  begin mul_a = mg_r;   mul_b = pp_r;  end
      skf_pkg::MUL_HP_H:  begin mul_a = hp_r;   mul_b = mg_r;  end
      skf_pkg::MUL_H_EP:  begin mul_a = mg_r;   mul_b = ep_r;  end
      skf_pkg::MUL_G_IN:  begin mul_a = gain_r; mul_b = in_r;  end
      skf_pkg::MUL_G_H:   begin mul_a = gain_r; mul_b = mg_r;  end
      skf_pkg::MUL_OM_PP: begin mul_a = om_r;   mul_b = pp_r;  end
      default:            begin mul_a = '0;     mul_b = '0;    end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // rounded product of the previous cycle
  assign qm = skf_pkg::qround(prod_r);

  // product register and temporaries
  always_ff @(posedge clk) begin
    if (cmd.in_load) begin
      z_r <= in_measurement;
    end
    if (cmd.mul_sel != skf_pkg::MUL_NONE) begin
      prod_r <= mul_p;
    end
    case (cmd.wr_sel)
      skf_pkg::WR_EPRED: ep_r  <= qm;
      skf_pkg::WR_T:     t_r   <= qm;
      skf_pkg::WR_INNOV: in_r  <= skf_pkg::sat33({z_r[31], z_r} - {qm[31], qm});
      skf_pkg::WR_PPRED: pp_r  <= skf_pkg::sat33({qm[31], qm} + {2'b00, qn_r});
      skf_pkg::WR_HP:    hp_r  <= qm;
      skf_pkg::WR_DEN:   den_r <= skf_pkg::sat33({qm[31], qm} + {2'b00, rn_r});
      skf_pkg::WR_OM:    om_r  <= skf_pkg::sat33({skf_pkg::Q_ONE[31], skf_pkg::Q_ONE}
                                                 - {qm[31], qm});
      default: ;
    endcase
    // gain and degenerate flag
    if (cmd.gain_zero) begin
      gain_r  <= '0;
      degen_r <= 1'b1;
    end else if (cmd.div_start) begin
      degen_r <= 1'b0;
    end
    if (div_done) begin
      gain_r <= div_quo;
    end
    // result word
    if (cmd.out_load) begin
      out_fv_r <= est_r;
      out_dg_r <= degen_r;
    end
  end

  // estimate and covariance
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      est_r <= '0;
      cov_r <= '0;
    end else begin
      if (cmd.wr_sel == skf_pkg::WR_EST) begin
        est_r <= skf_pkg::sat33({ep_r[31], ep_r} + {qm[31], qm});
      end
      if (cmd.wr_sel == skf_pkg::WR_COV) begin
        cov_r <= qm[31] ? 32'sd0 : qm;
      end
    end
  end

  // gain divider
  skf_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (hp_r),
    .den   (den_r[30:0]),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign sts.den_pos  = !den_r[31] && (|den_r[30:0]);
  assign sts.div_done = div_done;

  assign out_filtered_value = out_fv_r;
  assign out_degenerate     = out_dg_r;

endmodule

>>> sv/skf_ctrl.sv
`include "scalar_kalman_filter_macros.svh"

module skf_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  skf_pkg::skf_sts_t sts,
  output skf_pkg::skf_cmd_t cmd
);

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_MUL_AE,
    ST_MUL_AP,
    ST_MUL_HE,
    ST_MUL_TA,
    ST_PP,
    ST_MUL_HPP,
    ST_HP,
    ST_MUL_HPH,
    ST_DEN,
    ST_CHK,
    ST_DIV,
    ST_MUL_GI,
    ST_MUL_GH,
    ST_OM,
    ST_MUL_OMPP,
    ST_COV,
    ST_OUT
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_free;

  assign out_free = !out_valid_r || out_ready;

  // step sequence and commands
  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    cmd.mul_sel   = skf_pkg::MUL_NONE;
    cmd.wr_sel    = skf_pkg::WR_NONE;
    unique case (state_r)
      ST_IDLE: begin
        cmd.in_load = in_valid;
        if (in_valid) state_nxt = ST_MUL_AE;
      end
      ST_MUL_AE: begin
        cmd.mul_sel = skf_pkg::MUL_A_E;
        state_nxt   = ST_MUL_AP;
      end
      ST_MUL_AP: begin
        cmd.mul_sel = skf_pkg::MUL_A_P;
        cmd.wr_sel  = skf_pkg::WR_EPRED;
        state_nxt   = ST_MUL_HE;
      end
      ST_MUL_HE: begin
        cmd.mul_sel = skf_pkg::MUL_H_EP;
        cmd.wr_sel  = skf_pkg::WR_T;
        state_nxt   = ST_MUL_TA;
      end
      ST_MUL_TA: begin
        cmd.mul_sel = skf_pkg::MUL_T_A;
        cmd.wr_sel  = skf_pkg::WR_INNOV;
        state_nxt   = ST_PP;
      end
      ST_PP: begin
        cmd.wr_sel = skf_pkg::WR_PPRED;
        state_nxt  = ST_MUL_HPP;
      end
      ST_MUL_HPP: begin
        cmd.mul_sel = skf_pkg::MUL_H_PP;
        state_nxt   = ST_HP;
      end
      ST_HP: begin
        cmd.wr_sel = skf_pkg::WR_HP;
        state_nxt  = ST_MUL_HPH;
      end
      ST_MUL_HPH: begin
        cmd.mul_sel = skf_pkg::MUL_HP_H;
        state_nxt   = ST_DEN;
      end
      ST_DEN: begin
        cmd.wr_sel = skf_pkg::WR_DEN;
        state_nxt  = ST_CHK;
      end
      ST_CHK: begin
        if (sts.den_pos) begin
          cmd.div_start = 1'b1;
          state_nxt     = ST_DIV;
        end else begin
          cmd.gain_zero = 1'b1;
          state_nxt     = ST_MUL_GI;
        end
      end
      ST_DIV: begin
        if (sts.div_done) state_nxt = ST_MUL_GI;
      end
      ST_MUL_GI: begin
        cmd.mul_sel = skf_pkg::MUL_G_IN;
        state_nxt   = ST_MUL_GH;
      end
      ST_MUL_GH: begin
        cmd.mul_sel = skf_pkg::MUL_G_H;
        cmd.wr_sel  = skf_pkg::WR_EST;
        state_nxt   = ST_OM;
      end
      ST_OM: begin
        cmd.wr_sel = skf_pkg::WR_OM;
        state_nxt  = ST_MUL_OMPP;
      end
      ST_MUL_OMPP: begin
        cmd.mul_sel = skf_pkg::MUL_OM_PP;
        state_nxt   = ST_COV;
      end
      ST_COV: begin
        cmd.wr_sel = skf_pkg::WR_COV;
        state_nxt  = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  `SKF_ASSERT_NOW(a_div_needs_den, cmd.div_start, sts.den_pos, "divide started on zero den")
  `SKF_ASSERT_NOW(a_no_overwrite, cmd.out_load, out_free, "result word overwritten")
  `SKF_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready, "second word taken")

endmodule

>>> tb/sv/kalman_checker.sv
`timescale 1ns / 100ps
module kalman_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic signed [31:0] in_measurement,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [31:0] out_filtered_value,
  input  logic               out_degenerate,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_wdata,
  input  logic               check_end,
  output int                 mismatch_count
);

  localparam longint SAT_HI = 64'sd2147483647;
  localparam longint SAT_LO = -64'sd2147483648;

  typedef struct packed {
    logic signed [31:0] value;
    logic               degenerate;
  } filter_result_t;

  // shadow copy of the filter registers and state
  logic signed [31:0] gain_a;
  logic signed [31:0] gain_h;
  logic [30:0]        noise_q;
  logic [30:0]        noise_r;
  logic signed [31:0] est;
  logic signed [31:0] cov;

  filter_result_t estimate_q[$];
  int             result_idx;
  logic           checked_end = 1'b0;

  // clamp to the signed 32 bit range
  function automatic logic signed [31:0] q_sat(input longint v);
    if (v > SAT_HI) return 32'sh7FFF_FFFF;
    if (v < SAT_LO) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  // q16.16 product, round half up, saturate
  function automatic logic signed [31:0] q_mul(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
    longint p;
    p = longint'(a) * longint'(b) + 64'sd32768;
    return q_sat(p >>> 16);
  endfunction

  // q16.16 quotient on magnitudes, truncated, sign of the numerator
  function automatic logic signed [31:0] q_div(input logic signed [31:0] num,
                                               input logic signed [31:0] den);
    longint mag;
    longint quo;
    mag = (num < 0) ? -longint'(num) : longint'(num);
    quo = (mag <<< 16) / longint'(den);
    return q_sat((num < 0) ? -quo : quo);
  endfunction

  // one predict and update step, advances the shadow state
  function automatic filter_result_t advance_filter(input logic signed [31:0] z);
    logic signed [31:0] e_pred;
    logic signed [31:0] p_pred;
    logic signed [31:0] hp;
    logic signed [31:0] den;
    logic signed [31:0] gain;
    logic signed [31:0] innov;
    logic signed [31:0] one_minus;
    logic signed [31:0] p_new;
    filter_result_t     res;
    e_pred = q_mul(gain_a, est);
    p_pred = q_sat(longint'(q_mul(q_mul(gain_a, cov), gain_a)) + longint'({1'b0, noise_q}));
    hp     = q_mul(gain_h, p_pred);
    den    = q_sat(longint'(q_mul(hp, gain_h)) + longint'({1'b0, noise_r}));
    if (den > 0) begin
      gain = q_div(hp, den);
      res.degenerate = 1'b0;
    end else begin
      gain = '0;
      res.degenerate = 1'b1;
    end
    innov     = q_sat(longint'(z) - longint'(q_mul(gain_h, e_pred)));
    est       = q_sat(longint'(e_pred) + longint'(q_mul(gain, innov)));
    one_minus = q_sat(longint'(skf_pkg::Q_ONE) - longint'(q_mul(gain, gain_h)));
    p_new     = q_mul(one_minus, p_pred);
    cov       = (p_new < 0) ? 32'sd0 : p_new;
    res.value = est;
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  // watch the ports, predict on each input word, compare each result word
  always @(posedge clk) begin
    filter_result_t want;
    if (!rst_n) begin
      gain_a  = skf_pkg::STATE_GAIN_RST;
      gain_h  = skf_pkg::MEASURE_GAIN_RST;
      noise_q = skf_pkg::PROC_NOISE_RST;
      noise_r = skf_pkg::MEAS_NOISE_RST;
      est     = '0;
      cov     = '0;
      estimate_q.delete();
    end else begin
      // register writes
      if (cfg_we) begin
        case (cfg_index)
          skf_pkg::REG_STATE_GAIN:    gain_a  = cfg_wdata;
          skf_pkg::REG_MEASURE_GAIN:  gain_h  = cfg_wdata;
          skf_pkg::REG_PROCESS_NOISE: noise_q = cfg_wdata[30:0];
          skf_pkg::REG_MEASURE_NOISE: noise_r = cfg_wdata[30:0];
          default: ;
        endcase
      end
      // result word against the oldest expectation
      if (out_valid && out_ready) begin
        if (estimate_q.size() == 0) begin
          report_mismatch($sformatf("result %0d (value %0d) with nothing expected",
                                    result_idx, out_filtered_value));
        end else begin
          want = estimate_q.pop_front();
          if (out_filtered_value !== want.value)
            report_mismatch($sformatf("result %0d filtered_value %0d, expected %0d",
                                      result_idx, out_filtered_value, want.value));
          if (out_degenerate !== want.degenerate)
            report_mismatch($sformatf("result %0d degenerate %0b, expected %0b",
                                      result_idx, out_degenerate, want.degenerate));
        end
        result_idx++;
      end
      // input word
      if (in_valid && in_ready) estimate_q.push_back(advance_filter(in_measurement));
      // leftovers at the end of the run
      if (check_end && !checked_end) begin
        checked_end = 1'b1;
        if (estimate_q.size() != 0)
          report_mismatch($sformatf("%0d results never arrived", estimate_q.size()));
      end
    end
  end

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 100ps
module tb_top;

  localparam int RESET_CYCLES    = 5;
  localparam int RANDOM_PHASES   = 17;
  localparam int WORDS_PER_PHASE = 50;
  localparam int LONG_HOLD       = 400;
  localparam int FIRST_HOLD_AT   = 140;
  localparam int SECOND_HOLD_AT  = 600;
  localparam int SETTLE_CYCLES   = 4;
  localparam int TAIL_CYCLES     = 80;
  localparam int LIMIT_CYCLES    = 1000000;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic signed [31:0] in_measurement;
  logic               out_valid;
  logic               out_ready;
  logic signed [31:0] out_filtered_value;
  logic               out_degenerate;
  logic               cfg_we;
  logic [1:0]         cfg_index;
  logic [31:0]        cfg_wdata;
  logic               check_end;
  int                 mismatch_count;

  int sent_count;
  int rcv_count;
  int degen_count;
  int settings_count;
  int holds_done;
  int cycle_count;
  bit no_idle;

  scalar_kalman_filter DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_measurement     (in_measurement),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_filtered_value (out_filtered_value),
    .out_degenerate     (out_degenerate),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata)
  );

  kalman_checker CHK (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_measurement     (in_measurement),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_filtered_value (out_filtered_value),
    .out_degenerate     (out_degenerate),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .check_end          (check_end),
    .mismatch_count     (mismatch_count)
  );

  // clock
  initial clk = 1'b0;
  always #1 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d of %0d results seen",
               cycle_count, rcv_count, sent_count);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // result words taken
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      rcv_count++;
      if (out_degenerate) degen_count++;
    end
  end

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 50) return 0;
    if (sel < 85) return $urandom_range(1, 3);
    if (sel < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [31:0] pick_extreme_gain();
    case ($urandom_range(0, 4))
      0:       return skf_pkg::Q_MAX;
      1:       return skf_pkg::Q_MIN;
      2:       return 32'd0;
      3:       return skf_pkg::Q_ONE;
      default: return -skf_pkg::Q_ONE;
    endcase
  endfunction

  // state gain: mostly a stable range around 0.5 .. 1.1
  function automatic logic [31:0] pick_state_gain();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 15) return pick_extreme_gain();
    if (sel < 30) return $urandom;
    return $urandom_range(32768, 72090);
  endfunction

  // measurement gain: mostly within +-2.0
  function automatic logic [31:0] pick_measure_gain();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 15) return pick_extreme_gain();
    if (sel < 30) return $urandom;
    return int'($urandom_range(0, 262144)) - 131072;
  endfunction

  // noise variance: bit 31 is don't-care, so it is randomized
  function automatic logic [31:0] pick_noise(input int unsigned span);
    int          sel;
    logic [31:0] v;
    sel = $urandom_range(0, 99);
    if (sel < 15) begin
      case ($urandom_range(0, 3))
        0:       v = 32'd0;
        1:       v = 32'd1;
        2:       v = 32'h7FFF_FFFF;
        default: v = 32'hFFFF_FFFF;
      endcase
    end else if (sel < 30) begin
      v = $urandom;
    end else begin
      v = $urandom_range(0, span);
      v[31] = 1'($urandom_range(0, 1));
    end
    return v;
  endfunction

  // samples cluster around a per-phase center, with some wild ones
  function automatic logic [31:0] pick_measurement(input int center);
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 60) return center + int'($urandom_range(0, 131072)) - 65536;
    if (sel < 75) return int'($urandom_range(0, 131072)) - 65536;
    if (sel < 92) return $urandom;
    case ($urandom_range(0, 3))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'd0;
      default: return 32'hFFFF_FFFF;
    endcase
  endfunction

  // offer one word and hold it until taken; called at a falling edge
  task automatic send_word(input logic [31:0] word);
    int gap;
    gap = no_idle ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_measurement <= word;
    do @(posedge clk); while (!in_ready);
    sent_count++;
    @(negedge clk);
  endtask

  // stop offering and wait for every outstanding result
  task automatic drain();
    in_valid <= 1'b0;
    while (rcv_count != sent_count) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // write all four registers back to back
  task automatic load_config(input logic [31:0] a, input logic [31:0] h,
                             input logic [31:0] q, input logic [31:0] r);
    cfg_we    <= 1'b1;
    cfg_index <= skf_pkg::REG_STATE_GAIN;
    cfg_wdata <= a;
    @(negedge clk);
    cfg_index <= skf_pkg::REG_MEASURE_GAIN;
    cfg_wdata <= h;
    @(negedge clk);
    cfg_index <= skf_pkg::REG_PROCESS_NOISE;
    cfg_wdata <= q;
    @(negedge clk);
    cfg_index <= skf_pkg::REG_MEASURE_NOISE;
    cfg_wdata <= r;
    @(negedge clk);
    cfg_we <= 1'b0;
    settings_count++;
  endtask

  // receiver: random stalls, two long hold-offs while words keep coming
  initial begin
    int stall_left;
    stall_left = 0;
    out_ready  = 1'b0;
    forever begin
      @(negedge clk);
      if ((holds_done == 0 && rcv_count >= FIRST_HOLD_AT) ||
          (holds_done == 1 && rcv_count >= SECOND_HOLD_AT)) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk);
        holds_done++;
      end else if (no_idle || stall_left == 0) begin
        out_ready <= 1'b1;
        if (!no_idle) stall_left = pick_gap();
      end else begin
        out_ready <= 1'b0;
        stall_left--;
      end
    end
  end

  // stimulus and verdict
  initial begin
    int center;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_measurement = '0;
    cfg_we         = 1'b0;
    cfg_index      = skf_pkg::REG_STATE_GAIN;
    cfg_wdata      = '0;
    check_end      = 1'b0;
    no_idle        = 1'b0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset settings, field extremes and bit patterns
    send_word(32'd0);
    send_word(32'h7FFF_FFFF);
    send_word(32'h8000_0000);
    send_word(32'd65536);
    send_word(-32'sd65536);
    send_word(32'h5555_5555);
    send_word(32'hAAAA_AAAA);
    send_word(32'd1);
    drain();

    // register extremes, everything saturates
    load_config(skf_pkg::Q_MAX, skf_pkg::Q_MIN, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
    send_word(32'h7FFF_FFFF);
    send_word(32'h8000_0000);
    send_word(32'd0);
    drain();
    load_config(skf_pkg::Q_MIN, skf_pkg::Q_MAX, 32'd0, 32'd0);
    send_word(32'hFFFF_FFFF);
    send_word(32'd12345);
    drain();

    // zero denominator: measurement gain zero, then state gain zero
    load_config(skf_pkg::Q_ONE, 32'd0, 32'd0, 32'd0);
    send_word(32'd1000000);
    send_word(-32'sd5);
    drain();
    load_config(32'd0, skf_pkg::Q_ONE, 32'd0, 32'd0);
    send_word(32'd7);
    send_word(32'h8000_0000);
    drain();

    // negative gains
    load_config(-skf_pkg::Q_ONE, -32'sd131072, 32'd6553, 32'd1);
    send_word(32'd300000);
    send_word(-32'sd300000);
    send_word(32'd65536);
    drain();

    // tiny noise, gain near one, covariance clamp by rounding
    load_config(skf_pkg::Q_ONE, skf_pkg::Q_ONE, 32'd1, 32'd1);
    send_word(32'd131072);
    send_word(32'd196608);
    send_word(-32'sd65536);
    drain();

    // random phases, each under a fresh register setting
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      no_idle = (p % 4 == 2);
      load_config(pick_state_gain(), pick_measure_gain(), pick_noise(6553),
                  pick_noise(262144));
      center = int'($urandom_range(0, 2621440)) - 1310720;
      for (int k = 0; k < WORDS_PER_PHASE; k++) send_word(pick_measurement(center));
      drain();
    end
    no_idle = 1'b0;

    repeat (TAIL_CYCLES) @(negedge clk);
    check_end <= 1'b1;
    repeat (3) @(negedge clk);

    $display("run covered %0d measurement words under %0d register settings",
             sent_count, settings_count);
    $display("%0d results had a zero gain denominator, %0d long output hold-offs",
             degen_count, holds_done);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+sv
sv/skf_pkg.sv
sv/skf_div.sv
sv/skf_dp.sv
sv/skf_ctrl.sv
sv/scalar_kalman_filter.sv
tb/sv/kalman_checker.sv
tb/sv/tb_top.sv
